// ===== rtl/ccc_pkg.sv =====
// Shared types, codes and constants for the coin pulse credit controller.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package ccc_pkg;

    localparam int TS_BITS_DEFAULT = 32;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;

    typedef enum logic [1:0] {
        CMD_PULSE   = 2'd0,
        CMD_POLL    = 2'd1,
        CMD_ENABLE  = 2'd2,
        CMD_DISABLE = 2'd3
    } cmd_t;

    localparam logic [1:0] MODE_COIN_OP     = 2'd0;
    localparam logic [1:0] MODE_OPEN_PRICE  = 2'd1;
    localparam logic [1:0] MODE_FREE_CHARGE = 2'd2;

    localparam logic [1:0] KIND_AMOUNT = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_BUSY   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRICE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FREE_PRICE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_MIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_MAX    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COIN_STEP  = 3'd5;

    localparam logic [1:0]  RST_MODE       = MODE_COIN_OP;
    localparam logic [7:0]  RST_PRICE      = 8'd200;
    localparam logic [7:0]  RST_FREE_PRICE = 8'd10;
    localparam logic [15:0] RST_GAP_MIN    = 16'd125;
    localparam logic [15:0] RST_GAP_MAX    = 16'd135;
    localparam logic [7:0]  RST_COIN_STEP  = 8'd10;

    localparam logic [7:0] SEG_POINT  = 8'h80;
    localparam logic [7:0] SEG_TXT_R  = 8'h50;
    localparam logic [7:0] SEG_TXT_E  = 8'h79;
    localparam logic [7:0] SEG_TXT_U  = 8'h3E;
    localparam logic [7:0] SEG_TXT_S  = 8'h6D;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  price;
        logic [7:0]  free_price;
        logic [15:0] gap_min;
        logic [15:0] gap_max;
        logic [7:0]  coin_step;
    } cfg_t;

    typedef struct packed {
        logic       start_fired;
        logic       start_led;
        logic       coin_enable;
        logic [7:0] credit;
        logic       display_update;
        logic [1:0] display_kind;
        logic [7:0] digit_high;
        logic [7:0] digit_low;
    } res_t;

    // Seven-segment code of one decimal digit, segment A in bit 0.
    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/coin_pulse_credit_controller_core.sv =====
// Coin pulse credit controller, top level: input register, control, result register.
// An accepted item passes through the input register and then the result register before its result is offered.
// Throughput: one item per cycle while m_tready stays high; ccc_ctrl updates its state on every step.
// While a result waits, the input register still takes one more item before s_tready drops.
// Reset (rst_n low, asynchronous) empties both stages, loads the register defaults,
// clears credit and marks the display for refresh. Depends on ccc_pkg and its submodules.
`default_nettype none

module coin_pulse_credit_controller_core #(
    parameter int TIMESTAMP_BITS = ccc_pkg::TS_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [ccc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ccc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: pulse_time_ms [31:0], start_pressed [32], zero fill [39:33].
    input  wire logic [ccc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: cmd [1:0].
    input  wire logic [1:0]                      s_tuser,
    // Output stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: start_fired [0], start_led [1], coin_enable [2], credit_cents [10:3],
    // display_update [11], digit_high_segments [19:12], digit_low_segments [27:20],
    // zero fill [31:28].
    output logic      [ccc_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: display_kind [1:0].
    output logic      [1:0]                      m_tuser
);
    import ccc_pkg::*;

    cfg_t        cfg;
    res_t        res;

    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  cmd_reg;
    logic [31:0] time_reg;
    logic        pressed_reg;
    logic        step;
    logic        in_take;

    ccc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held item moves into the result register whenever that register is
    // empty or its result is being taken in the same cycle.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg     <= s_tuser;
            time_reg    <= s_tdata[31:0];
            pressed_reg <= s_tdata[32];
        end
    end

    ccc_ctrl #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step          (step),
        .cmd           (cmd_reg),
        .pulse_time_ms (time_reg),
        .start_pressed (pressed_reg),
        .res           (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res.display_kind;
    assign m_tdata  = {4'd0, res.digit_low, res.digit_high, res.display_update,
                       res.credit, res.coin_enable, res.start_led, res.start_fired};

endmodule

`default_nettype wire

// ===== rtl/ccc_cfg_regs.sv =====
// Configuration register file of the coin pulse credit controller.
// Depends on ccc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module ccc_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ccc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ccc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ccc_pkg::cfg_t                        cfg
);
    import ccc_pkg::*;

    cfg_t cfg_reg;

    // Writes to unused indexes fall through the default arm and change nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= RST_MODE;
            cfg_reg.price      <= RST_PRICE;
            cfg_reg.free_price <= RST_FREE_PRICE;
            cfg_reg.gap_min    <= RST_GAP_MIN;
            cfg_reg.gap_max    <= RST_GAP_MAX;
            cfg_reg.coin_step  <= RST_COIN_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:       cfg_reg.mode       <= cfg_wdata[1:0];
                REG_PRICE:      cfg_reg.price      <= cfg_wdata[7:0];
                REG_FREE_PRICE: cfg_reg.free_price <= cfg_wdata[7:0];
                REG_GAP_MIN:    cfg_reg.gap_min    <= cfg_wdata;
                REG_GAP_MAX:    cfg_reg.gap_max    <= cfg_wdata;
                REG_COIN_STEP:  cfg_reg.coin_step  <= cfg_wdata[7:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/ccc_seg_encode.sv =====
// Turns an 8-bit cent amount into the two seven-segment display positions.
// Depends on ccc_pkg for the digit table and the decimal point bit.
`default_nettype none

module ccc_seg_encode (
    input  wire logic [7:0] amount,
    output logic      [7:0] digit_high,
    output logic      [7:0] digit_low
);
    import ccc_pkg::*;

    logic [15:0] tens_prod;
    logic [4:0]  tens;
    logic [12:0] hund_prod;
    logic [1:0]  hund;
    logic [4:0]  hund_x10;
    logic [4:0]  tens_digit;

    // Divide by ten as multiply by 205 and shift by 11; exact for all 8-bit values.
    // Below 100 the hundreds digit comes out as zero, which gives the "0." lead.
    always_comb
    begin
        tens_prod  = 16'(amount) * 16'd205;
        tens       = tens_prod[15:11];
        hund_prod  = 13'(tens) * 13'd205;
        hund       = hund_prod[12:11];
        hund_x10   = 5'(hund) * 5'd10;
        tens_digit = tens - hund_x10;
        digit_high = seg_digit(4'(hund)) | SEG_POINT;
        digit_low  = seg_digit(tens_digit[3:0]);
    end

endmodule

`default_nettype wire

// ===== rtl/ccc_ctrl.sv =====
// Credit, acceptor and display state plus the result register.
// Depends on ccc_pkg and instantiates ccc_seg_encode.
`default_nettype none

module ccc_ctrl #(
    parameter int TIMESTAMP_BITS = ccc_pkg::TS_BITS_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ccc_pkg::cfg_t cfg,
    input  wire logic          step,
    input  wire logic [1:0]    cmd,
    input  wire logic [31:0]   pulse_time_ms,
    input  wire logic          start_pressed,
    output ccc_pkg::res_t      res
);
    import ccc_pkg::*;

    logic [7:0]                credit_reg, credit_next;
    logic [TIMESTAMP_BITS-1:0] last_time_reg, last_time_next;
    logic                      acc_on_reg, acc_on_next;
    logic                      led_reg, led_next;
    logic                      refresh_reg, refresh_next;
    res_t                      res_reg, res_next;

    logic [TIMESTAMP_BITS-1:0] now;
    logic [TIMESTAMP_BITS-1:0] gap;
    logic                      in_window;
    logic [7:0]                credit_src;
    logic [7:0]                amount;
    logic [7:0]                amt_high;
    logic [7:0]                amt_low;
    logic                      ok;
    logic                      fired;

    assign now       = TIMESTAMP_BITS'(pulse_time_ms);
    assign gap       = now - last_time_reg;
    assign in_window = (gap > TIMESTAMP_BITS'(cfg.gap_min))
                    && (gap < TIMESTAMP_BITS'(cfg.gap_max));

    // For an enable, the displayed amount is reckoned from a cleared credit.
    assign credit_src = (cmd_t'(cmd) == CMD_ENABLE) ? 8'd0 : credit_reg;
    assign amount = (cfg.mode == MODE_COIN_OP)
                  ? ((cfg.price > credit_src) ? (cfg.price - credit_src) : 8'd0)
                  : credit_src;

    ccc_seg_encode u_seg (
        .amount     (amount),
        .digit_high (amt_high),
        .digit_low  (amt_low)
    );

    always_comb
    begin
        credit_next    = credit_reg;
        last_time_next = last_time_reg;
        acc_on_next    = acc_on_reg;
        led_next       = led_reg;
        refresh_next   = refresh_reg;
        res_next       = '0;
        ok             = 1'b0;
        fired          = 1'b0;

        case (cmd_t'(cmd))
            CMD_PULSE:
            begin
                if (acc_on_reg)
                begin
                    last_time_next = now;
                    if (in_window)
                        credit_next = credit_reg + cfg.coin_step;
                    refresh_next = 1'b1;
                end
            end
            CMD_POLL:
            begin
                if (refresh_reg)
                begin
                    res_next.display_update = 1'b1;
                    refresh_next            = 1'b0;
                    if (cfg.mode == MODE_COIN_OP || cfg.mode == MODE_OPEN_PRICE)
                    begin
                        res_next.display_kind = KIND_AMOUNT;
                        res_next.digit_high   = amt_high;
                        res_next.digit_low    = amt_low;
                    end
                    else
                    begin
                        res_next.display_kind = KIND_FREE;
                        res_next.digit_high   = SEG_TXT_R;
                        res_next.digit_low    = SEG_TXT_E;
                    end
                end
                case (cfg.mode)
                    MODE_COIN_OP:     ok = credit_reg >= cfg.price;
                    MODE_OPEN_PRICE:  ok = credit_reg >= cfg.free_price;
                    MODE_FREE_CHARGE: ok = 1'b1;
                    default:          ok = 1'b0;
                endcase
                if (ok)
                begin
                    led_next = 1'b1;
                    fired    = start_pressed;
                end
                // A start overrides any refresh of this poll with the BUSY text.
                if (fired)
                begin
                    led_next                = 1'b0;
                    acc_on_next             = 1'b0;
                    credit_next             = 8'd0;
                    res_next.display_update = 1'b1;
                    res_next.display_kind   = KIND_BUSY;
                    res_next.digit_high     = SEG_TXT_U;
                    res_next.digit_low      = SEG_TXT_S;
                end
            end
            CMD_ENABLE:
            begin
                if (cfg.mode != MODE_FREE_CHARGE)
                begin
                    acc_on_next = 1'b1;
                    credit_next = 8'd0;
                end
                refresh_next            = 1'b0;
                res_next.display_update = 1'b1;
                if (cfg.mode == MODE_COIN_OP || cfg.mode == MODE_OPEN_PRICE)
                begin
                    res_next.display_kind = KIND_AMOUNT;
                    res_next.digit_high   = amt_high;
                    res_next.digit_low    = amt_low;
                end
                else
                begin
                    res_next.display_kind = KIND_FREE;
                    res_next.digit_high   = SEG_TXT_R;
                    res_next.digit_low    = SEG_TXT_E;
                end
            end
            default:
            begin
                acc_on_next = 1'b0;
                credit_next = 8'd0;
            end
        endcase

        res_next.start_fired = fired;
        res_next.start_led   = led_next;
        res_next.coin_enable = acc_on_next;
        res_next.credit      = credit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg    <= '0;
            last_time_reg <= '0;
            acc_on_reg    <= 1'b0;
            led_reg       <= 1'b0;
            refresh_reg   <= 1'b1;
        end
        else if (step)
        begin
            credit_reg    <= credit_next;
            last_time_reg <= last_time_next;
            acc_on_reg    <= acc_on_next;
            led_reg       <= led_next;
            refresh_reg   <= refresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire
